FILE: hw/rtl/ntpw_pkg.sv
// Shared constants, types and helpers for the nearest-two probe weights unit.
package ntpw_pkg;

   localparam int MaxProbes  = 256;
   localparam int CoordBits  = 24;
   localparam int IdxBits    = $clog2(MaxProbes);
   localparam int CntBits    = 9;
   localparam int DiffBits   = CoordBits + 1;
   localparam int SqBits     = 2 * DiffBits;
   localparam int DistSqBits = SqBits + 2;
   localparam int RootBits   = DistSqBits / 2;
   localparam int DistBits   = RootBits + 1;
   localparam int WeightBits = 16;
   localparam int PosWidth   = 3 * CoordBits;

   // scan pipe: ram read plus three datapath stages
   localparam int PipeLat  = 4;

   // divider widths
   localparam int NumBits  = DistBits + 16;
   localparam int DenBits  = DistBits + 1;
   localparam int StepBits = $clog2(NumBits + 1);

   localparam logic [WeightBits-1:0] WeightOne = 16'h8000;

   localparam logic OpLoad  = 1'b0;
   localparam logic OpQuery = 1'b1;

   localparam logic CsrProbeCount = 1'b0;
   localparam logic CsrSecondOn   = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_ROOT0 = 6'b000100,
      ST_ROOT1 = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic                   rd_en;
      logic [IdxBits-1:0]     rd_addr;
   } scan_rd_type;

endpackage

FILE: hw/rtl/nearest_two_probe_weights_unit.sv
// Top level of the nearest-two probe weights unit.
// Load request: written to the centre tables at once, no response, next request next cycle.
// Query request: scan of n centres at one per cycle through the distance pipe, two
// 26-step square roots and, with the second probe on, a 43-step divide, then the
// response strobe. One query at a time; busy is high from accept until the rsp_valid
// cycle; the receiver cannot stall.
// Synchronous active-high reset clears control and the registers (count 1, second on).
module nearest_two_probe_weights_unit
   import ntpw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [7:0]            req_center_index,
   input  logic signed [23:0]    req_pos_x,
   input  logic signed [23:0]    req_pos_y,
   input  logic signed [23:0]    req_pos_z,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_nearest_probe,
   output logic [7:0]            rsp_second_probe,
   output logic [15:0]           rsp_nearest_weight,
   output logic [15:0]           rsp_second_weight,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [8:0]            csr_wdata
);
   state_type state_ff, state_in;

   logic [CntBits-1:0]   count_ff;
   logic                 second_on_ff;
   logic [PosWidth-1:0]  sample_ff;

   // scan issue and pipe tracking
   logic [CntBits-1:0]   issue_ff, issue_in;
   logic [PipeLat-1:0]   vld_ff;
   logic [IdxBits-1:0]   tag_ff [PipeLat];
   logic                 last_issue;
   scan_rd_type          rd;

   // kept candidates
   logic [DistSqBits-1:0] b0_ff, b1_ff;
   logic [IdxBits-1:0]    i0_ff, i1_ff;
   logic                  have0_ff, have1_ff;
   logic [DistBits-1:0]   d0_ff;

   logic [CntBits-1:0]    n_eff;
   logic [PosWidth-1:0]   center;
   logic [DistSqBits-1:0] dist_sq;
   logic                  root_start, root_done, div_start, div_done;
   logic [DistSqBits-1:0] root_arg;
   logic [DistBits-1:0]   root_val;
   logic [WeightBits-1:0] quot;

   logic                  rsp_valid_ff;
   logic [15:0]           w0_ff, w1_ff;
   logic                  accept, load;

   assign accept = start && !busy;
   assign load   = accept && (req_operation == OpLoad);

   // clamp the count to one..table size
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CntBits'(1);
      end else if (count_ff > CntBits'(MaxProbes)) begin
         n_eff = CntBits'(MaxProbes);
      end else begin
         n_eff = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CntBits'(1);
         second_on_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CsrProbeCount: count_ff     <= csr_wdata;
            CsrSecondOn:   second_on_ff <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // three centre tables as one wide memory
   ntpw_ram #(.Width(PosWidth), .Depth(MaxProbes)) u_table (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (req_center_index[IdxBits-1:0]),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_en   (rd.rd_en),
      .rd_addr (rd.rd_addr),
      .rd_data (center)
   );

   ntpw_dist u_dist (
      .clock   (clock),
      .sample  (sample_ff),
      .center  (center),
      .dist_sq (dist_sq)
   );

   ntpw_math u_math (
      .clock      (clock),
      .reset      (reset),
      .root_start (root_start),
      .root_arg   (root_arg),
      .root_done  (root_done),
      .root_val   (root_val),
      .div_start  (div_start),
      .d0         (d0_ff),
      .d1         (root_val),
      .div_done   (div_done),
      .quot       (quot)
   );

   assign last_issue = (issue_ff == n_eff);
   assign rd.rd_en   = (state_ff == ST_SCAN) && !last_issue;
   assign rd.rd_addr = issue_ff[IdxBits-1:0];

   always_comb begin
      state_in   = state_ff;
      issue_in   = issue_ff;
      root_start = 1'b0;
      root_arg   = b0_ff;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            if (accept && req_operation == OpQuery) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!last_issue) begin
               issue_in = issue_ff + 1'b1;
            end else if (vld_ff == '0) begin
               // pipe drained: root of the nearest distance first
               root_start = 1'b1;
               state_in   = ST_ROOT0;
            end
         end
         ST_ROOT0: begin
            if (root_done) begin
               // one centre: second is the nearest
               root_start = 1'b1;
               root_arg   = have1_ff ? b1_ff : b0_ff;
               state_in   = ST_ROOT1;
            end
         end
         ST_ROOT1: begin
            if (root_done) begin
               if (second_on_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         have0_ff     <= 1'b0;
         have1_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= {vld_ff[PipeLat-2:0], rd.rd_en};
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (state_ff == ST_IDLE) begin
            have0_ff <= 1'b0;
            have1_ff <= 1'b0;
         end else if (vld_ff[PipeLat-1]) begin
            // strict less-than keeps the lower index on ties
            if (!have0_ff || dist_sq < b0_ff) begin
               have1_ff <= have0_ff;
               have0_ff <= 1'b1;
            end else if (!have1_ff || dist_sq < b1_ff) begin
               have1_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      tag_ff[0] <= rd.rd_addr;
      for (int k = 1; k < PipeLat; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
      if (accept) begin
         sample_ff <= {req_pos_z, req_pos_y, req_pos_x};
      end
      if (state_ff != ST_IDLE && vld_ff[PipeLat-1]) begin
         if (!have0_ff || dist_sq < b0_ff) begin
            b1_ff <= b0_ff;
            i1_ff <= i0_ff;
            b0_ff <= dist_sq;
            i0_ff <= tag_ff[PipeLat-1];
         end else if (!have1_ff || dist_sq < b1_ff) begin
            b1_ff <= dist_sq;
            i1_ff <= tag_ff[PipeLat-1];
         end
      end
      if (state_ff == ST_ROOT0 && root_done) begin
         d0_ff <= root_val;
      end
      if (state_ff == ST_ROOT1 && root_done && !second_on_ff) begin
         w0_ff <= WeightOne;
         w1_ff <= '0;
      end
      if (state_ff == ST_DIV && div_done) begin
         w0_ff <= quot;
         w1_ff <= WeightOne - quot;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_nearest_probe  = 8'(i0_ff);
   assign rsp_second_probe   = have1_ff ? 8'(i1_ff) : 8'(i0_ff);
   assign rsp_nearest_weight = w0_ff;
   assign rsp_second_weight  = w1_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE)
      else $error("response without completed query");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nearest_weight + rsp_second_weight) == 17'(WeightOne))
      else $error("weights do not sum to one");
   assert property (@(posedge clock) disable iff (reset)
      vld_ff != '0 |-> state_ff == ST_SCAN)
      else $error("scan pipe busy outside scan");
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a request");
endmodule

FILE: hw/rtl/ntpw_ram.sv
// Generic single-port-write, registered-read RAM.
module ntpw_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/ntpw_dist.sv
// Squared-distance datapath: difference, square, sum, one stage per register.
module ntpw_dist
   import ntpw_pkg::*;
(
   input  logic                     clock,
   input  logic [PosWidth-1:0]      sample,
   input  logic [PosWidth-1:0]      center,
   output logic [DistSqBits-1:0]    dist_sq
);
   logic signed [DiffBits-1:0] dx_ff, dy_ff, dz_ff;
   logic [SqBits-1:0]          sx_ff, sy_ff, sz_ff;
   logic [DistSqBits-1:0]      sum_ff;

   function automatic logic signed [DiffBits-1:0] diff(
      input logic [CoordBits-1:0] a,
      input logic [CoordBits-1:0] b
   );
      diff = DiffBits'(signed'(a)) - DiffBits'(signed'(b));
   endfunction

   function automatic logic [SqBits-1:0] sq(input logic signed [DiffBits-1:0] d);
      logic [DiffBits-1:0] m;
      m  = d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
      sq = SqBits'(m) * SqBits'(m);
   endfunction

   always_ff @(posedge clock) begin
      dx_ff  <= diff(sample[0 +: CoordBits], center[0 +: CoordBits]);
      dy_ff  <= diff(sample[CoordBits +: CoordBits], center[CoordBits +: CoordBits]);
      dz_ff  <= diff(sample[2*CoordBits +: CoordBits], center[2*CoordBits +: CoordBits]);
      sx_ff  <= sq(dx_ff);
      sy_ff  <= sq(dy_ff);
      sz_ff  <= sq(dz_ff);
      sum_ff <= DistSqBits'(sx_ff) + DistSqBits'(sy_ff) + DistSqBits'(sz_ff);
   end

   assign dist_sq = sum_ff;
endmodule

FILE: hw/rtl/ntpw_math.sv
// Iterative square root (rounded, clamped) and rounded divider for weights.
module ntpw_math
   import ntpw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  root_start,
   input  logic [DistSqBits-1:0] root_arg,
   output logic                  root_done,
   output logic [DistBits-1:0]   root_val,
   input  logic                  div_start,
   input  logic [DistBits-1:0]   d0,
   input  logic [DistBits-1:0]   d1,
   output logic                  div_done,
   output logic [WeightBits-1:0] quot
);
   // square root, one result bit per cycle
   logic [DistSqBits-1:0] rem_ff, rem_in, arg_ff;
   logic [RootBits-1:0]   root_ff, root_in;
   logic [StepBits-1:0]   rcnt_ff, rcnt_in;
   logic                  rbusy_ff, rbusy_in, rdone_ff, rdone_in;
   logic [DistSqBits-1:0] trial;
   logic [DistSqBits-1:0] rem_sh;
   logic [DistSqBits+1:0] sq_chk;

   always_comb begin
      rem_in   = rem_ff;
      root_in  = root_ff;
      rcnt_in  = rcnt_ff;
      rbusy_in = rbusy_ff;
      rdone_in = 1'b0;
      rem_sh   = {rem_ff[DistSqBits-3:0], arg_ff[DistSqBits-1 -: 2]};
      trial    = DistSqBits'({root_ff, 2'b01});
      if (root_start) begin
         rem_in   = '0;
         root_in  = '0;
         rcnt_in  = StepBits'(RootBits);
         rbusy_in = 1'b1;
      end else if (rbusy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RootBits-2:0], 1'b0};
         end
         rcnt_in = rcnt_ff - 1'b1;
         if (rcnt_ff == StepBits'(1)) begin
            rbusy_in = 1'b0;
            rdone_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbusy_ff <= 1'b0;
         rdone_ff <= 1'b0;
      end else begin
         rbusy_ff <= rbusy_in;
         rdone_ff <= rdone_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rcnt_ff <= rcnt_in;
      if (root_start) begin
         arg_ff <= root_arg;
      end else if (rbusy_ff) begin
         arg_ff <= {arg_ff[DistSqBits-3:0], 2'b00};
      end
   end

   // remainder above root rounds up; clamp zero to one LSB
   always_comb begin
      sq_chk = (DistSqBits+2)'(rem_ff);
      if (sq_chk > (DistSqBits+2)'(root_ff)) begin
         root_val = DistBits'(root_ff) + 1'b1;
      end else if (root_ff == '0) begin
         root_val = DistBits'(1);
      end else begin
         root_val = DistBits'(root_ff);
      end
   end
   assign root_done = rdone_ff;

   // restoring division of (d1*32768 + sum/2) by sum
   logic [NumBits-1:0]  num_ff, num_in;
   logic [DenBits-1:0]  den_ff, den_in;
   logic [DenBits:0]    prem_ff, prem_in;
   logic [NumBits-1:0]  q_ff, q_in;
   logic [StepBits-1:0] dcnt_ff, dcnt_in;
   logic                dbusy_ff, dbusy_in, ddone_ff, ddone_in;
   logic [DenBits-1:0]  sum;
   logic [DenBits:0]    psh;

   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      prem_in  = prem_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      ddone_in = 1'b0;
      sum      = DenBits'(d0) + DenBits'(d1);
      psh      = {prem_ff[DenBits-1:0], num_ff[NumBits-1]};
      if (div_start) begin
         num_in   = {d1, 15'd0} + NumBits'(sum >> 1);
         den_in   = sum;
         prem_in  = '0;
         q_in     = '0;
         dcnt_in  = StepBits'(NumBits);
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         num_in = {num_ff[NumBits-2:0], 1'b0};
         if (psh >= {1'b0, den_ff}) begin
            prem_in = psh - {1'b0, den_ff};
            q_in    = {q_ff[NumBits-2:0], 1'b1};
         end else begin
            prem_in = psh;
            q_in    = {q_ff[NumBits-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 1'b1;
         if (dcnt_ff == StepBits'(1)) begin
            dbusy_in = 1'b0;
            ddone_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in;
         ddone_ff <= ddone_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      prem_ff <= prem_in;
      q_ff    <= q_in;
      dcnt_ff <= dcnt_in;
   end

   assign quot     = q_ff[WeightBits-1:0];
   assign div_done = ddone_ff;

   assert property (@(posedge clock) disable iff (reset) root_done |-> !rbusy_ff)
      else $error("root done while still iterating");
   assert property (@(posedge clock) disable iff (reset) div_done |-> !dbusy_ff)
      else $error("divide done while still iterating");
   assert property (@(posedge clock) disable iff (reset) div_done |-> q_ff <= NumBits'(WeightOne))
      else $error("weight above one");
endmodule
